>>> rtl/rvie_pkg.sv
// ----------------------------------------------------------------------------
// rvie_pkg
// Shared types, opcodes and helpers for the register VM instruction executor.
// ----------------------------------------------------------------------------
package rvie_pkg;

    localparam int DATA_W  = 32;
    localparam int STACK_W = 13;
    localparam int ADDR2_W = 12;
    localparam int REG_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int LEN_W   = 4;

    // register roles
    localparam logic [REG_W-1:0] R_IP  = 4'd0;
    localparam logic [REG_W-1:0] R_ACC = 4'd1;
    localparam logic [REG_W-1:0] R_SP  = 4'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK = 1'd1;

    typedef enum logic [4:0] {
        OP_HALT        = 5'd0,
        OP_PUSH_LIT    = 5'd1,
        OP_PUSH_REG    = 5'd2,
        OP_POP_REG     = 5'd3,
        OP_MOV_LIT_REG = 5'd4,
        OP_MOV_REG_REG = 5'd5,
        OP_MOV_MEM_REG = 5'd6,
        OP_MOV_LIT_MEM = 5'd7,
        OP_MOV_REG_MEM = 5'd8,
        OP_MOV_MEM_MEM = 5'd9,
        OP_ADD_LIT_REG = 5'd10,
        OP_ADD_RRR     = 5'd11,
        OP_SUB_LIT_REG = 5'd12,
        OP_SUB_REG_REG = 5'd13,
        OP_INC_REG     = 5'd14,
        OP_INC_MEM     = 5'd15,
        OP_DEC_REG     = 5'd16,
        OP_DEC_MEM     = 5'd17,
        OP_JMP         = 5'd18,
        OP_JMP_NE      = 5'd19,
        OP_JMP_EQ      = 5'd20,
        OP_JMP_GT      = 5'd21,
        OP_JMP_GE      = 5'd22,
        OP_JMP_LT      = 5'd23,
        OP_JMP_LE      = 5'd24,
        OP_CALL        = 5'd25,
        OP_RETURN      = 5'd26,
        OP_START       = 5'd27
    } opcode_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_OPCODE = 2'd1,
        ERR_ADDR   = 2'd2
    } err_t;

    // which address check an instruction needs
    typedef enum logic [2:0] {
        CHK_NONE,
        CHK_PUSH,
        CHK_POP,
        CHK_A1,
        CHK_A1A2
    } chk_t;

    // decoded word handed from front to back
    typedef struct packed {
        opcode_t               op;
        logic [REG_W-1:0]      r1;
        logic [REG_W-1:0]      r2;
        logic [REG_W-1:0]      r3;
        logic [DATA_W-1:0]     lit;
        logic [DATA_W-1:0]     a1;
        logic [ADDR2_W-1:0]    a2;
        logic [LEN_W-1:0]      len;
        chk_t                  chk;
        logic                  unknown;
        logic                  mem_rd;
        logic                  is_start;
    } item_t;

    localparam int Q_DEPTH = 2;

    // instruction length in bytes
    function automatic logic [LEN_W-1:0] op_len(input opcode_t op);
        logic [LEN_W-1:0] n;
        case (op)
            OP_HALT, OP_CALL, OP_RETURN: n = 4'd1;
            OP_PUSH_REG, OP_POP_REG, OP_INC_REG, OP_DEC_REG: n = 4'd2;
            OP_MOV_REG_REG, OP_SUB_REG_REG: n = 4'd3;
            OP_ADD_RRR: n = 4'd4;
            OP_PUSH_LIT, OP_INC_MEM, OP_DEC_MEM, OP_JMP: n = 4'd5;
            OP_MOV_LIT_REG, OP_MOV_MEM_REG, OP_MOV_REG_MEM, OP_ADD_LIT_REG,
            OP_SUB_LIT_REG, OP_JMP_EQ, OP_JMP_GT, OP_JMP_GE, OP_JMP_LT,
            OP_JMP_LE: n = 4'd6;
            OP_JMP_NE: n = 4'd7;
            OP_MOV_LIT_MEM, OP_MOV_MEM_MEM: n = 4'd9;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // word aligned and inside the data memory
    function automatic logic addr_ok(input logic [DATA_W-1:0] a,
                                     input logic [DATA_W-1:0] words);
        return (a[1:0] == 2'b00) && (a[31:2] < words[29:0]);
    endfunction

endpackage

>>> rtl/rvie_if.sv
// ----------------------------------------------------------------------------
// rvie channel interfaces
// Instruction, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface rvie_cmd_if;
    logic        valid;
    logic        ready;
    logic [4:0]  opcode;
    logic [3:0]  reg_first;
    logic [3:0]  reg_second;
    logic [3:0]  reg_third;
    logic [31:0] literal;
    logic [31:0] addr_first;
    logic [11:0] addr_second;

    modport source (output valid, opcode, reg_first, reg_second, reg_third, literal,
                    addr_first, addr_second, input ready);
    modport sink   (input valid, opcode, reg_first, reg_second, reg_third, literal,
                    addr_first, addr_second, output ready);
endinterface

interface rvie_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_ip;
    logic [31:0] acc_value;
    logic        halted;
    logic [1:0]  error_code;

    modport source (output valid, next_ip, acc_value, halted, error_code, input ready);
    modport sink   (input valid, next_ip, acc_value, halted, error_code, output ready);
endinterface

interface rvie_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/rvie_ram.sv
// ----------------------------------------------------------------------------
// rvie_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module rvie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/rvie_front.sv
// ----------------------------------------------------------------------------
// rvie_front
// Accepts instruction words and classifies them for the execute side.
// ----------------------------------------------------------------------------
module rvie_front
    import rvie_pkg::*;
(
    rvie_cmd_if.sink cmd,
    input  logic     q_full,
    output logic     q_push,
    output item_t    q_wdata
);

    opcode_t op;

    assign op        = opcode_t'(cmd.opcode);
    assign cmd.ready = !q_full;
    assign q_push    = cmd.valid && !q_full;

    // decode
    always_comb
    begin
        q_wdata          = '0;
        q_wdata.op       = op;
        q_wdata.r1       = cmd.reg_first;
        q_wdata.r2       = cmd.reg_second;
        q_wdata.r3       = cmd.reg_third;
        q_wdata.lit      = cmd.literal;
        q_wdata.a1       = cmd.addr_first;
        q_wdata.a2       = cmd.addr_second;
        q_wdata.len      = op_len(op);
        q_wdata.unknown  = cmd.opcode > OP_START;
        q_wdata.is_start = op == OP_START;
        q_wdata.mem_rd   = 1'b0;
        q_wdata.chk      = CHK_NONE;
        case (op)
            OP_PUSH_LIT, OP_PUSH_REG: q_wdata.chk = CHK_PUSH;
            OP_POP_REG:
            begin
                q_wdata.chk    = CHK_POP;
                q_wdata.mem_rd = 1'b1;
            end
            OP_MOV_MEM_REG, OP_INC_MEM, OP_DEC_MEM:
            begin
                q_wdata.chk    = CHK_A1;
                q_wdata.mem_rd = 1'b1;
            end
            OP_MOV_LIT_MEM, OP_MOV_REG_MEM: q_wdata.chk = CHK_A1;
            OP_MOV_MEM_MEM:
            begin
                q_wdata.chk    = CHK_A1A2;
                q_wdata.mem_rd = 1'b1;
            end
            default: q_wdata.chk = CHK_NONE;
        endcase
    end

endmodule

>>> rtl/rvie_queue.sv
// ----------------------------------------------------------------------------
// rvie_queue
// Two-entry queue of decoded words between front and back.
// ----------------------------------------------------------------------------
module rvie_queue
    import rvie_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wdata,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output item_t rdata
);

    localparam int PW = $clog2(Q_DEPTH);

    item_t             slot_reg [Q_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;

    assign full  = count_reg == (PW+1)'(Q_DEPTH);
    assign valid = count_reg != '0;
    assign rdata = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/rvie_back.sv
// ----------------------------------------------------------------------------
// rvie_back
// Executes decoded words on the register file and the data memory.
// ----------------------------------------------------------------------------
module rvie_back
    import rvie_pkg::*;
#(
    parameter int NUM_REGS  = 16,
    parameter int MEM_WORDS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  item_t          q_rdata,
    output logic           q_pop,
    input  logic [31:0]    boot_ip,
    input  logic [12:0]    stack_top,
    rvie_res_if.source     res
);

    localparam int IW = $clog2(NUM_REGS);
    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [DATA_W-1:0] WORDS = DATA_W'(MEM_WORDS);

    typedef enum logic [1:0] {
        ST_EXEC = 2'b01,
        ST_MEM  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [31:0]       rf_reg [NUM_REGS];
    logic [31:0]       rf_next [NUM_REGS];
    logic              halt_reg, halt_next;
    logic              out_valid_reg;
    logic [31:0]       out_ip_reg, out_acc_reg;
    logic              out_halt_reg;
    err_t              out_err_reg;

    item_t             it;
    logic [31:0]       ip, acc, sp, sp_m4, ip_adv, a2_ext;
    logic [31:0]       r1v, r2v, r3v, mdata;
    logic              chk_fail, effect, need_rd, out_free, done;
    err_t              err;
    logic [31:0]       ip_n, sp_n, wr_val, mem_wdata;
    logic [REG_W-1:0]  wr_idx;
    logic              wr_en, mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;

    assign it     = q_rdata;
    assign ip     = rf_reg[R_IP[IW-1:0]];
    assign acc    = rf_reg[R_ACC[IW-1:0]];
    assign sp     = rf_reg[R_SP[IW-1:0]];
    assign sp_m4  = sp - 32'd4;
    assign ip_adv = ip + 32'(it.len);
    assign a2_ext = {20'd0, it.a2};

    // register operand reads; IP reads see the advanced value
    always_comb
    begin
        r1v = ({1'b0, it.r1} >= 5'(NUM_REGS)) ? 32'd0 :
              (it.r1 == R_IP) ? ip_adv : rf_reg[it.r1[IW-1:0]];
        r2v = ({1'b0, it.r2} >= 5'(NUM_REGS)) ? 32'd0 :
              (it.r2 == R_IP) ? ip_adv : rf_reg[it.r2[IW-1:0]];
        r3v = ({1'b0, it.r3} >= 5'(NUM_REGS)) ? 32'd0 :
              (it.r3 == R_IP) ? ip_adv : rf_reg[it.r3[IW-1:0]];
    end

    // address checks and error code
    always_comb
    begin
        case (it.chk)
            CHK_PUSH: chk_fail = !addr_ok(sp_m4, WORDS);
            CHK_POP:  chk_fail = !addr_ok(sp, WORDS);
            CHK_A1:   chk_fail = !addr_ok(it.a1, WORDS);
            CHK_A1A2: chk_fail = !addr_ok(it.a1, WORDS) ||
                                 !addr_ok(a2_ext, WORDS);
            default:  chk_fail = 1'b0;
        endcase
        if (it.is_start || halt_reg)
            err = ERR_OK;
        else if (it.unknown)
            err = ERR_OPCODE;
        else if (chk_fail)
            err = ERR_ADDR;
        else
            err = ERR_OK;
        effect  = it.is_start || (!halt_reg && err == ERR_OK);
        need_rd = effect && it.mem_rd;
    end

    // handshake with queue and output slot
    assign out_free  = !out_valid_reg || res.ready;
    assign done      = q_valid && out_free && (!need_rd || state_reg == ST_MEM);
    assign q_pop     = done;
    assign mem_re    = q_valid && need_rd && state_reg == ST_EXEC;
    assign mem_raddr = (it.chk == CHK_POP) ? sp[AW+1:2] : it.a1[AW+1:2];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EXEC: if (mem_re) state_next = ST_MEM;
            ST_MEM:  if (done) state_next = ST_EXEC;
            default: state_next = ST_EXEC;
        endcase
    end

    // execute
    always_comb
    begin
        ip_n      = ip;
        sp_n      = sp;
        halt_next = halt_reg;
        wr_en     = 1'b0;
        wr_idx    = it.r1;
        wr_val    = 32'd0;
        mem_we    = 1'b0;
        mem_waddr = it.a1[AW+1:2];
        mem_wdata = 32'd0;
        if (it.is_start)
        begin
            ip_n      = boot_ip;
            sp_n      = 32'(stack_top);
            halt_next = 1'b0;
        end
        else if (effect)
        begin
            ip_n = ip_adv;
            case (it.op)
                OP_HALT: halt_next = 1'b1;
                OP_PUSH_LIT, OP_PUSH_REG:
                begin
                    sp_n      = sp_m4;
                    mem_we    = 1'b1;
                    mem_waddr = sp_m4[AW+1:2];
                    mem_wdata = (it.op == OP_PUSH_LIT) ? it.lit : r1v;
                end
                OP_POP_REG:
                begin
                    sp_n   = sp + 32'd4;
                    wr_en  = 1'b1;
                    wr_val = mdata;
                end
                OP_MOV_LIT_REG:
                begin
                    wr_en  = 1'b1;
                    wr_val = it.lit;
                end
                OP_MOV_REG_REG:
                begin
                    wr_en  = 1'b1;
                    wr_idx = it.r2;
                    wr_val = r1v;
                end
                OP_MOV_MEM_REG:
                begin
                    wr_en  = 1'b1;
                    wr_val = mdata;
                end
                OP_MOV_LIT_MEM:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = it.lit;
                end
                OP_MOV_REG_MEM:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = r1v;
                end
                OP_MOV_MEM_MEM:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = a2_ext[AW+1:2];
                    mem_wdata = mdata;
                end
                OP_ADD_LIT_REG:
                begin
                    wr_en  = 1'b1;
                    wr_val = r1v + it.lit;
                end
                OP_ADD_RRR:
                begin
                    wr_en  = 1'b1;
                    wr_val = r2v + r3v;
                end
                OP_SUB_LIT_REG:
                begin
                    wr_en  = 1'b1;
                    wr_val = r1v - it.lit;
                end
                OP_SUB_REG_REG:
                begin
                    wr_en  = 1'b1;
                    wr_idx = it.r2;
                    wr_val = r2v - r1v;
                end
                OP_INC_REG:
                begin
                    wr_en  = 1'b1;
                    wr_val = r1v + 32'd1;
                end
                OP_DEC_REG:
                begin
                    wr_en  = 1'b1;
                    wr_val = r1v - 32'd1;
                end
                OP_INC_MEM:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mdata + 32'd1;
                end
                OP_DEC_MEM:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mdata - 32'd1;
                end
                OP_JMP:    ip_n = it.a1;
                OP_JMP_NE: if (r1v != r2v) ip_n = it.a1;
                OP_JMP_EQ: if (acc == r1v) ip_n = it.a1;
                OP_JMP_GT: if (acc >  r1v) ip_n = it.a1;
                OP_JMP_GE: if (acc >= r1v) ip_n = it.a1;
                OP_JMP_LT: if (acc <  r1v) ip_n = it.a1;
                OP_JMP_LE: if (acc <= r1v) ip_n = it.a1;
                default: ;
            endcase
        end
    end

    // register file next state; the destination write lands last
    always_comb
    begin
        for (int k = 0; k < NUM_REGS; k++)
        begin
            rf_next[k] = rf_reg[k];
            if (k == int'(R_IP))
                rf_next[k] = ip_n;
            if (k == int'(R_SP))
                rf_next[k] = sp_n;
            if (wr_en && ({1'b0, wr_idx} == 5'(k)))
                rf_next[k] = wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EXEC;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_REGS; k++)
                rf_reg[k] <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                halt_reg <= halt_next;
                for (int k = 0; k < NUM_REGS; k++)
                    rf_reg[k] <= rf_next[k];
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_ip_reg   <= rf_next[R_IP[IW-1:0]];
            out_acc_reg  <= rf_next[R_ACC[IW-1:0]];
            out_halt_reg <= halt_next;
            out_err_reg  <= err;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.next_ip    = out_ip_reg;
    assign res.acc_value  = out_acc_reg;
    assign res.halted     = out_halt_reg;
    assign res.error_code = out_err_reg;

    rvie_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (mem_we && done),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mdata)
    );

endmodule

>>> rtl/register_vm_instruction_executor.sv
// ----------------------------------------------------------------------------
// register_vm_instruction_executor
// Executes pre-decoded VM instructions on a register file and data memory.
// ----------------------------------------------------------------------------
// channel | dir | handshake     | word
// cmd     | in  | valid / ready | opcode, reg_first..third, literal, addr_first/second
// res     | out | valid / ready | next_ip, acc_value, halted, error_code
// cfg     | in  | valid / ready | index (0 boot IP, 1 stack_top), data
//
// One word per cycle for register and jump instructions while res is not stalled;
// instructions that read data memory (pop, memory moves, inc/dec of memory) issue
// the read first and complete from ST_MEM, as the data RAM has a registered read port.
// Reset clears registers, halt flag and queue; data memory is not cleared.
// A two-entry queue lets cmd accept up to two more words while res is stalled.
// ----------------------------------------------------------------------------
module register_vm_instruction_executor
    import rvie_pkg::*;
#(
    parameter int NUM_REGS  = 16,
    parameter int MEM_WORDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    rvie_cmd_if.sink    cmd,
    rvie_res_if.source  res,
    rvie_cfg_if.sink    cfg
);

    logic [31:0] boot_ip_reg;
    logic [12:0] stack_top_reg;
    logic        q_full, q_push, q_pop, q_valid;
    item_t       q_wdata, q_rdata;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_ip_reg   <= 32'd0;
            stack_top_reg <= 13'd4096;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ENTRY: boot_ip_reg   <= cfg.data;
                CFG_STACK: stack_top_reg <= cfg.data[12:0];
                default: ;
            endcase
        end
    end

    rvie_front u_front (
        .cmd     (cmd),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    rvie_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    rvie_back #(
        .NUM_REGS  (NUM_REGS),
        .MEM_WORDS (MEM_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .boot_ip   (boot_ip_reg),
        .stack_top (stack_top_reg),
        .res       (res)
    );

endmodule

>>> tb/rvie_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rvie testbench channel notes
// The block's channel interfaces live with the RTL; this file carries the
// small shared types that the checker and the stimulus use.
// ----------------------------------------------------------------------------
package rvie_tb_pkg;
    import rvie_pkg::*;

    // one instruction word as driven on cmd
    typedef struct {
        logic [4:0]  opcode;
        logic [3:0]  r1;
        logic [3:0]  r2;
        logic [3:0]  r3;
        logic [31:0] lit;
        logic [31:0] a1;
        logic [11:0] a2;
    } instr_t;

    // one result word as seen on res
    typedef struct {
        logic [31:0] ip;
        logic [31:0] acc;
        logic        halted;
        logic [1:0]  err;
    } outcome_t;
endpackage

>>> tb/rvie_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rvie_checker
// Watches the cmd, res and cfg channels, runs an executor model on every
// accepted instruction and compares each result word with the prediction.
// ----------------------------------------------------------------------------
module rvie_checker
    import rvie_pkg::*;
    import rvie_tb_pkg::*;
#(
    parameter int NUM_REGS  = 16,
    parameter int MEM_WORDS = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    rvie_cmd_if        cmd,
    rvie_res_if        res,
    rvie_cfg_if        cfg,
    output int         fail_count,
    output int         pending,
    output int         results_seen
);

    logic [31:0] regs [NUM_REGS];
    logic [31:0] dmem [MEM_WORDS];
    logic        halt_q;
    logic [31:0] entry_q;
    logic [31:0] stack_q;
    outcome_t    expected_q[$];

    function automatic logic mem_ok(input logic [31:0] a);
        return (a[1:0] == 2'b00) && (a[31:2] < MEM_WORDS);
    endfunction

    function automatic logic [31:0] rget(input logic [3:0] i);
        return (i < NUM_REGS) ? regs[i] : 32'd0;
    endfunction

    function automatic void rput(input logic [3:0] i, input logic [31:0] v);
        if (i < NUM_REGS)
            regs[i] = v;
    endfunction

    function automatic logic [3:0] instr_len(input logic [4:0] op);
        case (op)
            OP_HALT, OP_CALL, OP_RETURN:                     return 4'd1;
            OP_PUSH_REG, OP_POP_REG, OP_INC_REG, OP_DEC_REG: return 4'd2;
            OP_MOV_REG_REG, OP_SUB_REG_REG:                  return 4'd3;
            OP_ADD_RRR:                                      return 4'd4;
            OP_PUSH_LIT, OP_INC_MEM, OP_DEC_MEM, OP_JMP:     return 4'd5;
            OP_JMP_NE:                                       return 4'd7;
            OP_MOV_LIT_MEM, OP_MOV_MEM_MEM:                  return 4'd9;
            default:                                         return 4'd6;
        endcase
    endfunction

    // execute one instruction on the shadow machine
    function automatic outcome_t execute(input instr_t w);
        outcome_t o;
        logic [31:0] sp, acc, v;
        logic [1:0] err;
        logic take;
        err = ERR_OK;
        if (w.opcode == OP_START) begin
            regs[R_IP] = entry_q;
            regs[R_SP] = stack_q;
            halt_q = 1'b0;
        end else if (!halt_q) begin
            sp = regs[R_SP];
            if (w.opcode > OP_START)
                err = ERR_OPCODE;
            else if (w.opcode == OP_PUSH_LIT || w.opcode == OP_PUSH_REG) begin
                if (!mem_ok(sp - 32'd4)) err = ERR_ADDR;
            end else if (w.opcode == OP_POP_REG) begin
                if (!mem_ok(sp)) err = ERR_ADDR;
            end else if (w.opcode inside {OP_MOV_MEM_REG, OP_MOV_LIT_MEM, OP_MOV_REG_MEM,
                                          OP_INC_MEM, OP_DEC_MEM}) begin
                if (!mem_ok(w.a1)) err = ERR_ADDR;
            end else if (w.opcode == OP_MOV_MEM_MEM) begin
                if (!mem_ok(w.a1) || !mem_ok({20'd0, w.a2})) err = ERR_ADDR;
            end
            if (err == ERR_OK) begin
                regs[R_IP] = regs[R_IP] + instr_len(w.opcode);
                acc = regs[R_ACC];
                take = 1'b0;
                case (w.opcode)
                    OP_HALT: halt_q = 1'b1;
                    OP_PUSH_LIT, OP_PUSH_REG: begin
                        v = (w.opcode == OP_PUSH_LIT) ? w.lit : rget(w.r1);
                        sp = sp - 32'd4;
                        regs[R_SP] = sp;
                        dmem[sp[31:2]] = v;
                    end
                    OP_POP_REG: begin
                        v = dmem[sp[31:2]];
                        regs[R_SP] = sp + 32'd4;
                        rput(w.r1, v);
                    end
                    OP_MOV_LIT_REG: rput(w.r1, w.lit);
                    OP_MOV_REG_REG: rput(w.r2, rget(w.r1));
                    OP_MOV_MEM_REG: rput(w.r1, dmem[w.a1[31:2]]);
                    OP_MOV_LIT_MEM: dmem[w.a1[31:2]] = w.lit;
                    OP_MOV_REG_MEM: dmem[w.a1[31:2]] = rget(w.r1);
                    OP_MOV_MEM_MEM: dmem[w.a2[11:2]] = dmem[w.a1[31:2]];
                    OP_ADD_LIT_REG: rput(w.r1, rget(w.r1) + w.lit);
                    OP_ADD_RRR:     rput(w.r1, rget(w.r2) + rget(w.r3));
                    OP_SUB_LIT_REG: rput(w.r1, rget(w.r1) - w.lit);
                    OP_SUB_REG_REG: rput(w.r2, rget(w.r2) - rget(w.r1));
                    OP_INC_REG:     rput(w.r1, rget(w.r1) + 32'd1);
                    OP_INC_MEM:     dmem[w.a1[31:2]] = dmem[w.a1[31:2]] + 32'd1;
                    OP_DEC_REG:     rput(w.r1, rget(w.r1) - 32'd1);
                    OP_DEC_MEM:     dmem[w.a1[31:2]] = dmem[w.a1[31:2]] - 32'd1;
                    OP_JMP:         take = 1'b1;
                    OP_JMP_NE:      take = rget(w.r1) != rget(w.r2);
                    OP_JMP_EQ:      take = acc == rget(w.r1);
                    OP_JMP_GT:      take = acc > rget(w.r1);
                    OP_JMP_GE:      take = acc >= rget(w.r1);
                    OP_JMP_LT:      take = acc < rget(w.r1);
                    OP_JMP_LE:      take = acc <= rget(w.r1);
                    default: ;
                endcase
                if (take)
                    regs[R_IP] = w.a1;
            end
        end
        o.ip = regs[R_IP];
        o.acc = regs[R_ACC];
        o.halted = halt_q;
        o.err = err;
        return o;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        outcome_t w_exp;
        instr_t   w_in;
        if (!rst_n) begin
            for (int i = 0; i < NUM_REGS; i++)
                regs[i] = '0;
            halt_q = 1'b0;
            entry_q = 32'd0;
            stack_q = 32'd4096;
            expected_q.delete();
            fail_count = 0;
            results_seen = 0;
        end else begin
            // compare result word first, then predict the new word
            if (res.valid && res.ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $display("[%0t] unexpected result word", $time);
                    fail_count++;
                end else begin
                    w_exp = expected_q.pop_front();
                    if (res.next_ip !== w_exp.ip)
                        report("next_ip", res.next_ip, w_exp.ip);
                    if (res.acc_value !== w_exp.acc)
                        report("acc_value", res.acc_value, w_exp.acc);
                    if (res.halted !== w_exp.halted)
                        report("halted", res.halted, w_exp.halted);
                    if (res.error_code !== w_exp.err)
                        report("error_code", res.error_code, w_exp.err);
                end
            end
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == CFG_ENTRY)
                    entry_q = cfg.data;
                else
                    stack_q = {19'd0, cfg.data[12:0]};
            end
            if (cmd.valid && cmd.ready) begin
                w_in.opcode = cmd.opcode;
                w_in.r1 = cmd.reg_first;
                w_in.r2 = cmd.reg_second;
                w_in.r3 = cmd.reg_third;
                w_in.lit = cmd.literal;
                w_in.a1 = cmd.addr_first;
                w_in.a2 = cmd.addr_second;
                expected_q.push_back(execute(w_in));
            end
        end
    end

    assign pending = expected_q.size();

endmodule

>>> tb/register_vm_instruction_executor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_vm_instruction_executor_tb
// Drives directed and random instruction streams with random gaps on both
// sides, switches entry point and stack top between phases, and lets the
// checker compare every result word against its shadow executor.
// ----------------------------------------------------------------------------
module register_vm_instruction_executor_tb;
    import rvie_pkg::*;
    import rvie_tb_pkg::*;

    localparam int WATCHDOG = 5000;
    localparam int N_RANDOM = 1200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count, pending, results_seen;
    int   idle_cycles = 0;
    int   sent = 0;
    bit   hold_off = 1'b0;
    bit   stim_done = 1'b0;
    // words the stimulus has stored to memory, so reads stay on written data
    bit   written [1024];

    rvie_cmd_if cmd();
    rvie_res_if res();
    rvie_cfg_if cfg();

    register_vm_instruction_executor DUT (.clk(clk), .rst_n(rst_n), .cmd(cmd),
                                          .res(res), .cfg(cfg));

    rvie_checker CHK (.clk(clk), .rst_n(rst_n), .cmd(cmd), .res(res), .cfg(cfg),
                      .fail_count(fail_count), .pending(pending),
                      .results_seen(results_seen));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, sometimes long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                res.ready <= 1'b0;
                repeat (60) @(negedge clk);
                hold_off = 1'b0;
            end
            res.ready <= ($urandom_range(0, 3) != 0) || stim_done;
        end
    end

    // watchdog on accepted traffic
    always @(posedge clk) begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d words outstanding", pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send(input instr_t w);
        int g;
        cmd.valid <= 1'b1;
        cmd.opcode <= w.opcode;
        cmd.reg_first <= w.r1;
        cmd.reg_second <= w.r2;
        cmd.reg_third <= w.r3;
        cmd.literal <= w.lit;
        cmd.addr_first <= w.a1;
        cmd.addr_second <= w.a2;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        sent++;
        @(negedge clk);
        // the next word may go out on this same edge, so only drop valid on a gap
        g = gap_len();
        if (g == 0 && $urandom_range(0, 9) == 0) g = 1;
        if (g > 0) begin
            cmd.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic cfg_write(input logic [0:0] idx, input logic [31:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= d;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic instr_t blank(input logic [4:0] op);
        instr_t w;
        w.opcode = op;
        w.r1 = $urandom_range(0, 15);
        w.r2 = $urandom_range(0, 15);
        w.r3 = $urandom_range(0, 15);
        w.lit = $urandom;
        w.a1 = $urandom;
        w.a2 = $urandom;
        return w;
    endfunction

    // shadow of the stack pointer and halt flag, to keep pops on written words
    logic [31:0] sp_shadow, ep_shadow, st_shadow;
    bit halted_shadow;

    // aligned address of a word already written, else all ones when none is found
    function automatic logic [31:0] rd_addr();
        int k;
        for (int t = 0; t < 8; t++) begin
            k = $urandom_range(0, 1023);
            if (written[k]) return k * 4;
        end
        return 32'hFFFF_FFFF;
    endfunction

    // build one random instruction; memory reads only touch written words
    function automatic instr_t pick();
        instr_t w;
        int r;
        logic [31:0] a;
        r = $urandom_range(0, 99);
        if (r < 3) w = blank($urandom_range(28, 31));
        else if (r < 5) w = blank(OP_HALT);
        else if (r < 9) w = blank(OP_START);
        else w = blank($urandom_range(1, 26));
        // keep register operands mostly low so IP/ACC/SP interplay is frequent
        if ($urandom_range(0, 3) != 0) begin
            w.r1 = $urandom_range(0, 5);
            w.r2 = $urandom_range(0, 5);
            w.r3 = $urandom_range(0, 5);
        end
        if ($urandom_range(0, 1)) w.lit = $urandom_range(0, 16);
        case (w.opcode)
            OP_MOV_LIT_MEM, OP_MOV_REG_MEM: begin
                if ($urandom_range(0, 9) != 0) w.a1 = $urandom_range(0, 1023) * 4;
                // stores are ignored while halted
                if (!halted_shadow && w.a1[1:0] == 0 && w.a1[31:2] < 1024)
                    written[w.a1[31:2]] = 1'b1;
            end
            OP_MOV_MEM_REG, OP_INC_MEM, OP_DEC_MEM, OP_MOV_MEM_MEM: begin
                a = rd_addr();
                if (a != 32'hFFFF_FFFF && $urandom_range(0, 9) != 0) w.a1 = a;
                else if (w.a1[1:0] == 0 && w.a1[31:2] < 1024) w.a1[0] = 1'b1;
                if (w.opcode == OP_MOV_MEM_MEM && w.a1[1:0] == 0 && w.a1 < 4096) begin
                    if ($urandom_range(0, 7) != 0) w.a2[1:0] = 2'b00;
                    if (!halted_shadow && w.a2[1:0] == 0) written[w.a2[11:2]] = 1'b1;
                end
            end
            OP_JMP, OP_JMP_NE, OP_JMP_EQ, OP_JMP_GT, OP_JMP_GE, OP_JMP_LT, OP_JMP_LE:
                if ($urandom_range(0, 1)) w.a1 = $urandom_range(0, 255);
            default: ;
        endcase
        return w;
    endfunction

    // track only what pops need; any doubt turns the pop into a push
    function automatic instr_t stack_safe(input instr_t w);
        bit mov_sp;
        if (w.opcode == OP_POP_REG && !halted_shadow) begin
            if (sp_shadow[1:0] == 0 && sp_shadow < 4096 && !written[sp_shadow[11:2]])
                w.opcode = OP_PUSH_LIT;
        end
        // register writes to SP other than stack ops lose track: avoid them
        mov_sp = (w.opcode inside {OP_MOV_LIT_REG, OP_MOV_MEM_REG, OP_ADD_LIT_REG,
                  OP_ADD_RRR, OP_SUB_LIT_REG, OP_INC_REG, OP_DEC_REG}
                  && w.r1 == R_SP) ||
                 (w.opcode inside {OP_MOV_REG_REG, OP_SUB_REG_REG} && w.r2 == R_SP) ||
                 (w.opcode == OP_POP_REG && w.r1 == R_SP);
        if (mov_sp) w.opcode = OP_CALL;
        if (w.opcode == OP_START) begin
            sp_shadow = st_shadow;
            halted_shadow = 1'b0;
        end else if (!halted_shadow) begin
            if (w.opcode == OP_HALT) halted_shadow = 1'b1;
            else if (w.opcode inside {OP_PUSH_LIT, OP_PUSH_REG}) begin
                if ((sp_shadow - 4) % 4 == 0 && (sp_shadow - 4) < 4096) begin
                    sp_shadow = sp_shadow - 4;
                    written[sp_shadow[11:2]] = 1'b1;
                end
            end else if (w.opcode == OP_POP_REG) begin
                if (sp_shadow[1:0] == 0 && sp_shadow < 4096) sp_shadow = sp_shadow + 4;
            end
        end
        return w;
    endfunction

    initial
    begin
        instr_t w;
        logic [31:0] st_vals [4];
        cmd.valid = 1'b0;
        cmd.opcode = '0; cmd.reg_first = '0; cmd.reg_second = '0; cmd.reg_third = '0;
        cmd.literal = '0; cmd.addr_first = '0; cmd.addr_second = '0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        sp_shadow = 0; ep_shadow = 0; st_shadow = 4096; halted_shadow = 0;
        st_vals = '{32'd4096, 32'd0, 32'd2048, 32'd4094};
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: boundary writes, extremes and each special case
        cfg_write(CFG_ENTRY, 32'hFFFF_FFF0);
        cfg_write(CFG_STACK, 32'd4096);
        ep_shadow = 32'hFFFF_FFF0; st_shadow = 4096;
        w = blank(OP_PUSH_LIT);   w = stack_safe(w); send(w); // SP 0: range error
        w = blank(OP_START);      w = stack_safe(w); send(w);
        w = blank(OP_MOV_LIT_REG); w.r1 = R_ACC; w.lit = 32'hFFFF_FFFF; send(w);
        w = blank(OP_INC_REG);    w.r1 = R_ACC; send(w);      // wraps to zero
        w = blank(OP_DEC_REG);    w.r1 = R_ACC; send(w);
        w = blank(OP_PUSH_REG);   w.r1 = R_SP; w = stack_safe(w); send(w);
        w = blank(OP_PUSH_LIT);   w.lit = 32'hDEAD_BEEF; w = stack_safe(w); send(w);
        w = blank(OP_POP_REG);    w.r1 = 4'd15; w = stack_safe(w); send(w);
        w = blank(OP_MOV_REG_REG); w.r1 = R_IP; w.r2 = R_ACC; send(w); // advanced IP
        w = blank(OP_MOV_LIT_MEM); w.a1 = 32'd4092; w.lit = 32'h8000_0000;
        written[1023] = 1'b1; send(w);
        w = blank(OP_MOV_LIT_MEM); w.a1 = 32'd4096; send(w);   // out of range
        w = blank(OP_MOV_LIT_MEM); w.a1 = 32'd2; send(w);      // misaligned
        w = blank(OP_MOV_MEM_MEM); w.a1 = 32'd4092; w.a2 = 12'd0;
        written[0] = 1'b1; send(w);
        w = blank(OP_INC_MEM);    w.a1 = 32'd0; send(w);
        w = blank(OP_MOV_MEM_REG); w.a1 = 32'd0; w.r1 = R_ACC; send(w);
        w = blank(OP_JMP_NE);     w.r1 = R_ACC; w.r2 = 4'd3; w.a1 = 32'd0; send(w);
        w = blank(OP_JMP_GE);     w.r1 = 4'd9; w.a1 = 32'hFFFF_FFFF; send(w);
        w = blank(OP_MOV_LIT_REG); w.r1 = R_IP; w.lit = 32'h40; send(w);
        w = blank(31);            send(w);                     // unknown opcode
        w = blank(OP_HALT);       w = stack_safe(w); send(w);
        w = blank(OP_ADD_LIT_REG); w = stack_safe(w); send(w); // ignored while halted
        w = blank(OP_START);      w = stack_safe(w); send(w);
        drain();

        // random phases with a new configuration each
        for (int ph = 0; ph < 4; ph++) begin
            ep_shadow = (ph == 1) ? 32'd0 : $urandom;
            st_shadow = st_vals[ph];
            cfg_write(CFG_ENTRY, ep_shadow);
            cfg_write(CFG_STACK, st_shadow);
            w = blank(OP_START); w = stack_safe(w); send(w);
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                if (ph == 1 && i == 20) hold_off = 1'b1;
                w = stack_safe(pick());
                send(w);
            end
            drain();
        end

        stim_done = 1'b1;
        drain();
        $display("sent %0d instruction words, checked %0d result words", sent, results_seen);
        $display("covered all opcodes, address errors, halt and restart, four stack tops");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
